>>> src/wsfd_pkg.sv
// shared types, constants and helpers of the websocket frame deframer
package wsfd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_LIMITS_EN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_LIM  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MSG_LIM    = 2'd2;

  localparam logic [31:0] FRAME_LIM_RESET = 32'd1048576;
  localparam logic [31:0] MSG_LIM_RESET   = 32'd4194304;

  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_EMPTY      = 2'd1;
  localparam logic [1:0] KIND_PEER_CLOSE = 2'd2;
  localparam logic [1:0] KIND_VIOLATION  = 2'd3;

  localparam logic [1:0] CLASS_TEXT = 2'd0;
  localparam logic [1:0] CLASS_PING = 2'd2;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [15:0] CODE_NORMAL   = 16'd1000;
  localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
  localparam logic [15:0] CODE_TOO_BIG  = 16'd1009;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [1:0]  cls;
    logic        lf;
    logic        lm;
    logic [15:0] code;
  } word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code;
  } close_ans_t;

  // answer to a peer close once its payload is in
  function automatic close_ans_t close_answer(input logic [63:0] len,
                                              input logic [15:0] c);
    close_ans_t a;
    a.kind = KIND_PEER_CLOSE;
    a.code = c;
    if (len == 64'd0) begin
      a.code = CODE_NORMAL;
    end else if (len == 64'd1) begin
      a.kind = KIND_VIOLATION;
      a.code = CODE_PROTOCOL;
    end else if (c < 16'd1000 || (c > 16'd1003 && c < 16'd1007) ||
                 (c > 16'd1011 && c < 16'd3000) || c > 16'd4999) begin
      a.kind = KIND_VIOLATION;
      a.code = CODE_PROTOCOL;
    end
    return a;
  endfunction

endpackage

>>> src/websocket_frame_deframer_unit.sv
// top level of the websocket frame deframer
// Usage: received connection bytes arrive on rx_byte_i with in_valid_i; a
// byte is taken at a clock edge where in_valid_i is high and in_stall_o low.
// Each byte gives at most one output word (result_kind_o and the fields with
// it) on out_valid_o, taken when out_stall_i is low.
// Throughput is one byte per cycle while in_stall_o is low: header parsing,
// limit checks and unmasking are all decided in the cycle the byte is taken.
// From byte to word: the parser writes a two-entry word queue at the edge
// that takes the byte, and the output register loads from the queue when
// it holds no word or its word is taken, raising out_valid_o.
// When the receiver stalls, words collect in the queue; in_stall_o rises
// once the queue is full and falls the cycle after a word moves on.
// Configuration (limits enable, frame limit, message limit) is written via
// cfg_we_i / cfg_index_i / cfg_data_i while the block is idle.
// Reset clears the parser to expect a frame header, opens the stream and
// loads the default limits; after any close all further bytes are taken
// and dropped until the next reset.
module websocket_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  msg_class_o,
  output logic        last_of_frame_o,
  output logic        last_of_message_o,
  output logic [15:0] close_code_o,
  input  logic        cfg_we_i,
  input  logic [wsfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic        limits_en_q;
  logic [31:0] frame_lim_q, msg_lim_q;
  logic        acc, push, pop, q_empty, q_full;
  wsfd_pkg::word_t fw, qw, ow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_en_q <= 1'b1;
      frame_lim_q <= wsfd_pkg::FRAME_LIM_RESET;
      msg_lim_q   <= wsfd_pkg::MSG_LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wsfd_pkg::CFG_LIMITS_EN: limits_en_q <= cfg_data_i[0];
        wsfd_pkg::CFG_FRAME_LIM: frame_lim_q <= cfg_data_i;
        wsfd_pkg::CFG_MSG_LIM:   msg_lim_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign acc = in_valid_i && !q_full;

  wsfd_front u_front (
    .clk_i, .rst_ni, .acc_i(acc), .rx_byte_i,
    .limits_en_i(limits_en_q), .frame_lim_i(frame_lim_q), .msg_lim_i(msg_lim_q),
    .push_o(push), .word_o(fw)
  );

  wsfd_queue #(.Depth(wsfd_pkg::QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(fw), .pop_i(pop),
    .rdata_o(qw), .empty_o(q_empty), .full_o(q_full)
  );

  wsfd_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_word_i(qw), .q_pop_o(pop),
    .out_stall_i, .out_valid_o, .out_word_o(ow)
  );

  assign result_kind_o     = ow.kind;
  assign data_byte_o       = ow.data;
  assign msg_class_o       = ow.cls;
  assign last_of_frame_o   = ow.lf;
  assign last_of_message_o = ow.lm;
  assign close_code_o      = ow.code;

endmodule

>>> src/wsfd_front.sv
// front end: header parser, rule checks and payload unmasking, one byte a cycle
module wsfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 limits_en_i,
  input  logic [31:0]          frame_lim_i,
  input  logic [31:0]          msg_lim_i,
  output logic                 push_o,
  output wsfd_pkg::word_t      word_o
);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        final_q, final_d;
  logic [3:0]  op_q, op_d;
  logic        masked_q, masked_d;
  logic [63:0] fl_q, fl_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  midx_q, midx_d;
  logic        frag_q, frag_d;
  logic        bin_q, bin_d;
  logic [63:0] tot_q, tot_d;
  logic [15:0] cc_q, cc_d;
  logic        closed_q, closed_d;

  logic        after_len, do_finish, last;
  logic [64:0] sum;
  logic [7:0]  kbyte, dbyte;
  logic [63:0] pos;
  wsfd_pkg::close_ans_t ans;
  wsfd_pkg::word_t w;
  logic        wv;

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; final_d = final_q; op_d = op_q;
    masked_d = masked_q; fl_d = fl_q; rem_d = rem_q; key_d = key_q;
    midx_d = midx_q; frag_d = frag_q; bin_d = bin_q; tot_d = tot_q;
    cc_d = cc_q; closed_d = closed_q;
    after_len = 1'b0; do_finish = 1'b0; last = 1'b0;
    w = '0; wv = 1'b0;
    sum = 65'd0; kbyte = 8'd0; dbyte = 8'd0; pos = 64'd0; ans = '0;
    if (!closed_q) begin
      unique case (phase_q)
        PH_HDR0: begin
          if (rx_byte_i[6:4] != 3'd0 ||
              (rx_byte_i[3:0] >= 4'd3 && rx_byte_i[3:0] <= 4'd7) ||
              rx_byte_i[3:0] >= 4'd11) begin
            closed_d = 1'b1; wv = 1'b1;
            w.kind = wsfd_pkg::KIND_VIOLATION; w.code = wsfd_pkg::CODE_PROTOCOL;
          end else begin
            final_d = rx_byte_i[7];
            op_d = rx_byte_i[3:0];
            phase_d = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked_d = rx_byte_i[7];
          if (rx_byte_i[6:0] >= 7'd126) begin
            fl_d = 64'd0;
            cnt_d = (rx_byte_i[6:0] == 7'd126) ? 4'd2 : 4'd8;
            phase_d = PH_EXTLEN;
          end else begin
            fl_d = {57'd0, rx_byte_i[6:0]};
            after_len = 1'b1;
          end
        end
        PH_EXTLEN: begin
          fl_d = {fl_q[55:0], rx_byte_i};
          cnt_d = cnt_q - 4'd1;
          after_len = (cnt_d == 4'd0);
        end
        PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_q - 4'd1;
          do_finish = (cnt_d == 4'd0);
        end
        PH_PAYLOAD: begin
          pos = fl_q - rem_q;
          if (masked_q) begin
            unique case (midx_q)
              2'd0: kbyte = key_q[31:24];
              2'd1: kbyte = key_q[23:16];
              2'd2: kbyte = key_q[15:8];
              default: kbyte = key_q[7:0];
            endcase
          end
          dbyte = rx_byte_i ^ kbyte;
          midx_d = midx_q + 2'd1;
          rem_d = rem_q - 64'd1;
          last = (rem_d == 64'd0);
          if (last) phase_d = PH_HDR0;
          if (op_q == wsfd_pkg::OP_CLOSE) begin
            if (pos == 64'd0) cc_d = {dbyte, 8'd0};
            else if (pos == 64'd1) cc_d = {cc_q[15:8], dbyte};
            if (last) begin
              ans = wsfd_pkg::close_answer(fl_q, cc_d);
              closed_d = 1'b1; wv = 1'b1; w.kind = ans.kind; w.code = ans.code;
            end
          end else if (op_q == wsfd_pkg::OP_PING) begin
            wv = 1'b1; w.kind = wsfd_pkg::KIND_DATA; w.data = dbyte;
            w.cls = wsfd_pkg::CLASS_PING; w.lf = last; w.lm = last;
          end else if (op_q != wsfd_pkg::OP_PONG) begin
            wv = 1'b1; w.kind = wsfd_pkg::KIND_DATA; w.data = dbyte;
            w.cls = {1'b0, bin_q}; w.lf = last; w.lm = last & final_q;
          end
        end
        default: phase_d = PH_HDR0;
      endcase

      if (after_len) begin
        if (masked_d) begin
          key_d = 32'd0; cnt_d = 4'd4; phase_d = PH_MASK;
        end else begin
          do_finish = 1'b1;
        end
      end

      if (do_finish) begin
        midx_d = 2'd0; rem_d = fl_d; cc_d = 16'd0;
        sum = {1'b0, tot_q} + {1'b0, fl_d};
        if (op_q == wsfd_pkg::OP_CONT) tot_d = sum[64] ? '1 : sum[63:0];
        priority if (limits_en_i && fl_d > {32'd0, frame_lim_i}) begin
          closed_d = 1'b1; wv = 1'b1;
          w.kind = wsfd_pkg::KIND_VIOLATION; w.code = wsfd_pkg::CODE_TOO_BIG;
        end else if (limits_en_i && tot_d > {32'd0, msg_lim_i}) begin
          closed_d = 1'b1; wv = 1'b1;
          w.kind = wsfd_pkg::KIND_VIOLATION; w.code = wsfd_pkg::CODE_TOO_BIG;
        end else if ((frag_q && (op_q == wsfd_pkg::OP_TEXT || op_q == wsfd_pkg::OP_BINARY))
                     || (op_q[3] && !final_q) || (op_q[3] && fl_d > 64'd125)
                     || (op_q == wsfd_pkg::OP_CONT && !frag_q)) begin
          closed_d = 1'b1; wv = 1'b1;
          w.kind = wsfd_pkg::KIND_VIOLATION; w.code = wsfd_pkg::CODE_PROTOCOL;
        end else begin
          if (op_q == wsfd_pkg::OP_TEXT || op_q == wsfd_pkg::OP_BINARY) begin
            bin_d = (op_q == wsfd_pkg::OP_BINARY);
            if (final_q) begin
              tot_d = 64'd0;
            end else begin
              frag_d = 1'b1; tot_d = fl_d;
            end
          end else if (op_q == wsfd_pkg::OP_CONT && final_q) begin
            frag_d = 1'b0; tot_d = 64'd0;
          end
          if (fl_d == 64'd0) begin
            phase_d = PH_HDR0;
            // empty frame marker (none for a pong), or an immediate close answer
            if (op_q == wsfd_pkg::OP_PING) begin
              wv = 1'b1; w.kind = wsfd_pkg::KIND_EMPTY; w.cls = wsfd_pkg::CLASS_PING;
              w.lf = 1'b1; w.lm = 1'b1;
            end else if (op_q == wsfd_pkg::OP_CLOSE) begin
              closed_d = 1'b1; wv = 1'b1;
              w.kind = wsfd_pkg::KIND_PEER_CLOSE; w.code = wsfd_pkg::CODE_NORMAL;
            end else if (op_q != wsfd_pkg::OP_PONG) begin
              wv = 1'b1; w.kind = wsfd_pkg::KIND_EMPTY; w.cls = {1'b0, bin_d};
              w.lf = 1'b1; w.lm = final_q;
            end
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
    end
  end

  assign push_o = acc_i && wv;
  assign word_o = w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0; cnt_q <= '0; final_q <= 1'b0; op_q <= '0;
      masked_q <= 1'b0; fl_q <= '0; rem_q <= '0; key_q <= '0; midx_q <= '0;
      frag_q <= 1'b0; bin_q <= 1'b0; tot_q <= '0; cc_q <= '0; closed_q <= 1'b0;
    end else if (acc_i) begin
      phase_q <= phase_d; cnt_q <= cnt_d; final_q <= final_d; op_q <= op_d;
      masked_q <= masked_d; fl_q <= fl_d; rem_q <= rem_d; key_q <= key_d;
      midx_q <= midx_d; frag_q <= frag_d; bin_q <= bin_d; tot_q <= tot_d;
      cc_q <= cc_d; closed_q <= closed_d;
    end
  end

  a_closed_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q) else $error("closed stream reopened");
  a_no_word_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> !push_o) else $error("word produced after close");
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD && !closed_q) |-> rem_q != 64'd0)
    else $error("payload phase with nothing left");

endmodule

>>> src/wsfd_queue.sv
// short word queue between parser and output stage
module wsfd_queue #(
  parameter int unsigned Depth = wsfd_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wsfd_pkg::word_t wdata_i,
  input  logic            pop_i,
  output wsfd_pkg::word_t rdata_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  wsfd_pkg::word_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");

endmodule

>>> src/wsfd_back.sv
// back end: output register that hands queued words to the receiver
module wsfd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  wsfd_pkg::word_t q_word_i,
  output logic            q_pop_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output wsfd_pkg::word_t out_word_o
);

  logic            valid_q;
  wsfd_pkg::word_t word_q;

  assign q_pop_o     = !q_empty_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) word_q <= q_word_i;
  end

endmodule

>>> dv/tb.sv
// self-checking testbench of the websocket frame deframer unit
`timescale 1ns / 1ps

module tb;

  // frame parser prediction and the store of expected output words
  class deframer_scoreboard;
    typedef enum {PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD} phase_e;
    logic        limits_en;
    logic [31:0] frame_lim, msg_lim;
    phase_e      phase;
    logic [3:0]  hcount, op;
    logic        fin, masked, in_frag, bin, closed;
    logic [63:0] flen, remaining, total;
    logic [31:0] key;
    logic [1:0]  midx;
    logic [15:0] capture;
    wsfd_pkg::word_t expected_words[$];
    int          errors;

    function new();
      limits_en = 1'b1;
      frame_lim = wsfd_pkg::FRAME_LIM_RESET;
      msg_lim   = wsfd_pkg::MSG_LIM_RESET;
      phase = PH_HDR0;
      hcount = '0; op = '0; fin = 0; masked = 0; in_frag = 0; bin = 0; closed = 0;
      flen = '0; remaining = '0; total = '0; key = '0; midx = '0; capture = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void push(logic [1:0] kind, logic [7:0] d, logic [1:0] cls, logic lf,
                       logic lm, logic [15:0] code);
      wsfd_pkg::word_t w;
      w.kind = kind; w.data = d; w.cls = cls; w.lf = lf; w.lm = lm; w.code = code;
      expected_words.push_back(w);
    endfunction

    function void close_with(logic [1:0] kind, logic [15:0] code);
      closed = 1'b1;
      push(kind, 8'd0, wsfd_pkg::CLASS_TEXT, 1'b0, 1'b0, code);
    endfunction

    function void answer_close();
      if (flen == 64'd0) close_with(wsfd_pkg::KIND_PEER_CLOSE, wsfd_pkg::CODE_NORMAL);
      else if (flen == 64'd1) close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_PROTOCOL);
      else if (capture < 1000 || (capture >= 1004 && capture <= 1006) ||
               (capture >= 1012 && capture <= 2999) || capture > 4999)
        close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_PROTOCOL);
      else close_with(wsfd_pkg::KIND_PEER_CLOSE, capture);
    endfunction

    function void finish_header();
      logic [63:0] sum;
      midx = '0;
      remaining = flen;
      capture = '0;
      if (op == wsfd_pkg::OP_CONT) begin
        sum = total + flen;
        total = (sum < total) ? '1 : sum;
      end
      if (limits_en && flen > {32'd0, frame_lim})
        close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_TOO_BIG);
      else if (limits_en && total > {32'd0, msg_lim})
        close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_TOO_BIG);
      else if (in_frag && (op == wsfd_pkg::OP_TEXT || op == wsfd_pkg::OP_BINARY))
        close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_PROTOCOL);
      else if (op[3] && !fin) close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_PROTOCOL);
      else if (op[3] && flen > 125)
        close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_PROTOCOL);
      else if (op == wsfd_pkg::OP_CONT && !in_frag)
        close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_PROTOCOL);
      else begin
        if (op == wsfd_pkg::OP_TEXT || op == wsfd_pkg::OP_BINARY) begin
          bin = (op == wsfd_pkg::OP_BINARY);
          if (fin) begin
            total = '0;
          end else begin
            in_frag = 1'b1;
            total = flen;
          end
        end else if (op == wsfd_pkg::OP_CONT && fin) begin
          in_frag = 1'b0;
          total = '0;
        end
        if (flen == 64'd0) begin
          phase = PH_HDR0;
          case (op)
            wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY:
              push(wsfd_pkg::KIND_EMPTY, 8'd0, {1'b0, bin}, 1'b1, fin, 16'd0);
            wsfd_pkg::OP_PING:
              push(wsfd_pkg::KIND_EMPTY, 8'd0, wsfd_pkg::CLASS_PING, 1'b1, 1'b1, 16'd0);
            wsfd_pkg::OP_CLOSE: answer_close();
            default: ;
          endcase
        end else begin
          phase = PH_PAYLOAD;
        end
      end
    endfunction

    function void after_length();
      if (masked) begin
        key = '0;
        hcount = 4'd4;
        phase = PH_MASK;
      end else begin
        finish_header();
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [63:0] pos;
      logic [7:0]  d;
      logic        last;
      if (closed) return;
      case (phase)
        PH_HDR0: begin
          if (b[6:4] != 3'd0 ||
              !(b[3:0] inside {wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY,
                               wsfd_pkg::OP_CLOSE, wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG}))
            close_with(wsfd_pkg::KIND_VIOLATION, wsfd_pkg::CODE_PROTOCOL);
          else begin
            fin = b[7];
            op = b[3:0];
            phase = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked = b[7];
          if (b[6:0] >= 7'd126) begin
            flen = '0;
            hcount = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
            phase = PH_EXTLEN;
          end else begin
            flen = {57'd0, b[6:0]};
            after_length();
          end
        end
        PH_EXTLEN: begin
          flen = {flen[55:0], b};
          hcount--;
          if (hcount == 0) after_length();
        end
        PH_MASK: begin
          key = {key[23:0], b};
          hcount--;
          if (hcount == 0) finish_header();
        end
        default: begin
          pos = flen - remaining;
          d = masked ? b ^ key[31 - 8 * midx -: 8] : b;
          midx++;
          remaining--;
          last = (remaining == 0);
          if (last) phase = PH_HDR0;
          case (op)
            wsfd_pkg::OP_CLOSE: begin
              if (pos == 0) capture = {d, 8'd0};
              else if (pos == 1) capture[7:0] = d;
              if (last) answer_close();
            end
            wsfd_pkg::OP_PONG: ;
            wsfd_pkg::OP_PING:
              push(wsfd_pkg::KIND_DATA, d, wsfd_pkg::CLASS_PING, last, last, 16'd0);
            default: push(wsfd_pkg::KIND_DATA, d, {1'b0, bin}, last, last & fin, 16'd0);
          endcase
        end
      endcase
    endfunction

    function void field_check(string name, int e, int a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_word(wsfd_pkg::word_t act);
      wsfd_pkg::word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %p", $time, act);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      field_check("result_kind", e.kind, act.kind);
      field_check("data_byte", e.data, act.data);
      field_check("msg_class", e.cls, act.cls);
      field_check("last_of_frame", e.lf, act.lf);
      field_check("last_of_message", e.lm, act.lm);
      field_check("close_code", e.code, act.code);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  data_byte_o;
  logic [1:0]  msg_class_o;
  logic        last_of_frame_o;
  logic        last_of_message_o;
  logic [15:0] close_code_o;
  logic        cfg_we_i;
  logic [wsfd_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  deframer_scoreboard sb = new();
  int  bytes_sent = 0;
  int  hold_len = 0;
  int  idle_cycles = 0;
  bit  quiet = 0;

  websocket_frame_deframer_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      out_stall_i <= 1'b1;
      hold_len--;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 26);
    end
  end

  always @(posedge clk_i) begin
    wsfd_pkg::word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      w.kind = result_kind_o; w.data = data_byte_o; w.cls = msg_class_o;
      w.lf = last_of_frame_o; w.lm = last_of_message_o; w.code = close_code_o;
      sb.check_word(w);
    end
  end

  // watchdog on cycles where no word moves on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 3000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (!quiet && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    sb.note_byte(b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic en, logic [31:0] fl, logic [31:0] ml);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= wsfd_pkg::CFG_LIMITS_EN;
    cfg_data_i <= {31'd0, en};
    @(posedge clk_i);
    cfg_index_i <= wsfd_pkg::CFG_FRAME_LIM;
    cfg_data_i <= fl;
    @(posedge clk_i);
    cfg_index_i <= wsfd_pkg::CFG_MSG_LIM;
    cfg_data_i <= ml;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limits_en = en;
    sb.frame_lim = fl;
    sb.msg_lim = ml;
  endtask

  // form 0: 7-bit length, 1: 16-bit, 2: 64-bit; pre gives leading payload bytes
  task automatic send_frame(logic [7:0] h0, logic [63:0] len, int form, bit msk, int n,
                            logic [7:0] pre[$]);
    logic [31:0] k;
    logic [7:0]  p;
    k = $urandom;
    send_byte(h0);
    if (form == 0) begin
      send_byte({msk, len[6:0]});
    end else if (form == 1) begin
      send_byte({msk, 7'd126});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({msk, 7'd127});
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (msk) for (int i = 3; i >= 0; i--) send_byte(k[8 * i +: 8]);
    for (int i = 0; i < n; i++) begin
      p = (i < pre.size()) ? pre[i] : 8'($urandom);
      send_byte(msk ? p ^ k[31 - 8 * (i % 4) -: 8] : p);
    end
  endtask

  task automatic frame(logic fin, logic [3:0] op, int len);
    logic [7:0] none[$];
    int form;
    form = (len >= 126) ? $urandom_range(1, 2) :
           ($urandom_range(9) < 8) ? 0 : $urandom_range(1, 2);
    send_frame({fin, 3'd0, op}, 64'(len), form, 1'($urandom_range(1)), len, none);
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 88) return $urandom_range(1, 20);
    return $urandom_range(100, 200);
  endfunction

  task automatic random_message();
    int sel;
    logic [3:0] op;
    sel = $urandom_range(9);
    op = $urandom_range(1) ? wsfd_pkg::OP_BINARY : wsfd_pkg::OP_TEXT;
    if (sel < 4) begin
      frame(1'b1, op, rand_len());
    end else if (sel < 7) begin
      frame(1'b0, op, rand_len());
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(2) == 0)
          frame(1'b1, $urandom_range(1) ? wsfd_pkg::OP_PING : wsfd_pkg::OP_PONG,
                $urandom_range(0, 125));
        frame(1'b0, wsfd_pkg::OP_CONT, rand_len());
      end
      frame(1'b1, wsfd_pkg::OP_CONT, rand_len());
    end else if (sel < 9) begin
      frame(1'b1, wsfd_pkg::OP_PING, $urandom_range(0, 125));
    end else begin
      frame(1'b1, wsfd_pkg::OP_PONG, $urandom_range(0, 125));
    end
  endtask

  task automatic run_until(int target);
    while (bytes_sent < target) random_message();
  endtask

  initial begin
    logic [7:0]  pre[$];
    logic [15:0] code;
    logic [3:0]  bad_op;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = wsfd_pkg::CFG_LIMITS_EN;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte extremes, opcodes but close, empty frames, 7/16-bit length
    pre = '{8'h00, 8'hFF};
    send_frame({1'b1, 3'd0, wsfd_pkg::OP_TEXT}, 64'd2, 0, 1'b1, 2, pre);
    send_frame({1'b1, 3'd0, wsfd_pkg::OP_BINARY}, 64'd0, 0, 1'b0, 0, pre);
    send_frame({1'b1, 3'd0, wsfd_pkg::OP_PING}, 64'd1, 0, 1'b0, 1, pre);
    send_frame({1'b1, 3'd0, wsfd_pkg::OP_PONG}, 64'd0, 0, 1'b0, 0, pre);
    send_frame({1'b0, 3'd0, wsfd_pkg::OP_BINARY}, 64'd1, 1, 1'b0, 1, pre);
    send_frame({1'b1, 3'd0, wsfd_pkg::OP_CONT}, 64'd0, 0, 1'b0, 0, pre);

    run_until(250);
    write_cfg(1'b0, 32'd0, 32'd0);
    quiet = 1;
    run_until(450);
    quiet = 0;
    write_cfg(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hold_len = 80;
    run_until(650);
    write_cfg(1'b1, 32'd200, 32'd1000);
    run_until(900);
    drain();

    // ending: one way to close and bytes that must be ignored, or a huge frame
    pre.delete();
    case ($urandom_range(12))
      0: send_byte({1'($urandom_range(1)), 3'($urandom_range(1, 7)), wsfd_pkg::OP_TEXT});
      1: begin
        bad_op = $urandom_range(1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        send_byte({1'b1, 3'd0, bad_op});
      end
      2: begin
        write_cfg(1'b1, 32'd10, 32'hFFFF_FFFF);
        frame(1'b1, wsfd_pkg::OP_TEXT, 11);
      end
      3: begin
        write_cfg(1'b1, 32'hFFFF_FFFF, 32'd30);
        frame(1'b0, wsfd_pkg::OP_TEXT, 20);
        frame(1'b0, wsfd_pkg::OP_CONT, 20);
      end
      4: begin
        frame(1'b0, wsfd_pkg::OP_TEXT, 3);
        frame(1'b1, wsfd_pkg::OP_BINARY, 2);
      end
      5: frame(1'b0, wsfd_pkg::OP_PING, 2);
      6: send_frame({1'b1, 3'd0, wsfd_pkg::OP_PING}, 64'd126, 1, 1'b1, 0, pre);
      7: frame(1'b1, wsfd_pkg::OP_CONT, 3);
      8: frame(1'b1, wsfd_pkg::OP_CLOSE, 0);
      9: frame(1'b1, wsfd_pkg::OP_CLOSE, 1);
      10: begin
        case ($urandom_range(2))
          0: code = 16'($urandom_range(1000, 1003));
          1: code = 16'($urandom_range(1007, 1011));
          default: code = 16'($urandom_range(3000, 4999));
        endcase
        pre = '{code[15:8], code[7:0]};
        send_frame({1'b1, 3'd0, wsfd_pkg::OP_CLOSE}, 64'd5, 0, 1'($urandom_range(1)), 5,
                   pre);
      end
      11: begin
        case ($urandom_range(3))
          0: code = 16'($urandom_range(0, 999));
          1: code = 16'($urandom_range(1004, 1006));
          2: code = 16'($urandom_range(1012, 2999));
          default: code = 16'($urandom_range(5000, 65535));
        endcase
        pre = '{code[15:8], code[7:0]};
        send_frame({1'b1, 3'd0, wsfd_pkg::OP_CLOSE}, 64'd2, 0, 1'($urandom_range(1)), 2,
                   pre);
      end
      default: begin
        // full 64-bit length with the top bit set, limits off
        write_cfg(1'b0, 32'd0, 32'd0);
        send_frame({1'b1, 3'd0, wsfd_pkg::OP_TEXT}, 64'hFFFF_FFFF_FFFF_FFF0, 2, 1'b1, 10,
                   pre);
      end
    endcase
    repeat (20) send_byte(8'($urandom));

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected words never arrived", $time, sb.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/wsfd_pkg.sv
src/wsfd_front.sv
src/wsfd_queue.sv
src/wsfd_back.sv
src/websocket_frame_deframer_unit.sv
dv/tb.sv
